// File: src/aff2d_pkg.sv
package aff2d_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   localparam logic signed [34:0] Q30_PI       = 35'sd3373259426;
   localparam logic signed [34:0] Q30_TWO_PI   = 35'sd6746518852;
   localparam logic signed [34:0] Q30_HALF_PI  = 35'sd1686629713;
   localparam logic signed [33:0] Q30_INV_GAIN = 34'sd652032874;

   localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048576, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
      30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
   };

   typedef struct packed {
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [19:0] angle;
      logic signed [23:0] stretch_x;
      logic signed [23:0] stretch_y;
      logic signed [31:0] pivot_x;
      logic signed [31:0] pivot_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
   } rsp_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [34:0] z;
      logic               flip;
   } cord_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// File: src/aff2d_cordic.sv
module aff2d_cordic
   import aff2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  req_type            in_data,
   output logic               out_valid,
   output req_type            out_data,
   output logic signed [17:0] out_cos,
   output logic signed [17:0] out_sin
);

   logic              wrap_vld_ff;
   req_type           wrap_tag_ff;
   logic signed [34:0] wrap_z_ff, wrap_z_in;

   logic              vld_ff [0:STEPS];
   req_type           tag_ff [0:STEPS];
   cord_type          st_ff  [0:STEPS];
   cord_type          fold_in;

   logic              out_vld_ff;
   req_type           out_tag_ff;
   logic signed [17:0] cos_ff, sin_ff, cos_in, sin_in;

   // wrap into [-pi, pi]
   always_comb begin
      logic signed [34:0] z;
      z = {in_data.angle[19], in_data.angle, 14'd0};
      if (z > Q30_PI) begin
         wrap_z_in = z - Q30_TWO_PI;
      end else if (z < -Q30_PI) begin
         wrap_z_in = z + Q30_TWO_PI;
      end else begin
         wrap_z_in = z;
      end
   end

   // fold into [-pi/2, pi/2], flip signs of the result
   always_comb begin
      fold_in.x = Q30_INV_GAIN;
      fold_in.y = '0;
      fold_in.flip = 1'b0;
      fold_in.z = wrap_z_ff;
      if (wrap_z_ff > Q30_HALF_PI) begin
         fold_in.z = wrap_z_ff - Q30_PI;
         fold_in.flip = 1'b1;
      end else if (wrap_z_ff < -Q30_HALF_PI) begin
         fold_in.z = wrap_z_ff + Q30_PI;
         fold_in.flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      wrap_z_ff   <= wrap_z_in;
      wrap_tag_ff <= in_data;
      st_ff[0]    <= fold_in;
      tag_ff[0]   <= wrap_tag_ff;
      if (reset) begin
         wrap_vld_ff <= 1'b0;
         vld_ff[0]   <= 1'b0;
      end else begin
         wrap_vld_ff <= in_valid;
         vld_ff[0]   <= wrap_vld_ff;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      cord_type step_in;
      always_comb begin
         logic signed [34:0] ang;
         ang = {5'd0, ATAN_Q30[i]};
         step_in.flip = st_ff[i].flip;
         if (!st_ff[i].z[34]) begin
            step_in.x = st_ff[i].x - (st_ff[i].y >>> i);
            step_in.y = st_ff[i].y + (st_ff[i].x >>> i);
            step_in.z = st_ff[i].z - ang;
         end else begin
            step_in.x = st_ff[i].x + (st_ff[i].y >>> i);
            step_in.y = st_ff[i].y - (st_ff[i].x >>> i);
            step_in.z = st_ff[i].z + ang;
         end
      end
      always_ff @(posedge clock) begin
         st_ff[i+1]  <= step_in;
         tag_ff[i+1] <= tag_ff[i];
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   always_comb begin
      logic signed [34:0] cr, sr;
      cr = (35'(st_ff[STEPS].x) + 35'sd8192) >>> 14;
      sr = (35'(st_ff[STEPS].y) + 35'sd8192) >>> 14;
      if (st_ff[STEPS].flip) begin
         cos_in = -cr[17:0];
         sin_in = -sr[17:0];
      end else begin
         cos_in = cr[17:0];
         sin_in = sr[17:0];
      end
   end

   always_ff @(posedge clock) begin
      cos_ff     <= cos_in;
      sin_ff     <= sin_in;
      out_tag_ff <= tag_ff[STEPS];
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_tag_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

endmodule

// File: src/affine_2d_transform_matrix.sv
// 2D affine matrix builder: translate * pivot * rotate * scale * unpivot.
// Pulse start with req_data (move, angle, stretch, pivot) to launch a
// transfer; the block is fully pipelined, so busy stays low and a new item
// may be started every cycle. Sine and cosine come from a CORDIC with one
// register stage per iteration.
// Pipeline: two angle-folding stages, one register stage per CORDIC
// iteration, one for rounding, then five for the scale products, their
// rounding, the pivot products, the sums and the final saturation.
// Throughput: one item per cycle.
// Each result shows on rsp_data for exactly one cycle with rsp_valid high;
// the receiver cannot hold results off and none are dropped.
// Synchronous reset clears all valid bits; items in flight are discarded.
module affine_2d_transform_matrix
   import aff2d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic               cs_vld;
   req_type            cs_tag;
   logic signed [17:0] cs_cos, cs_sin;

   aff2d_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_data   (req_data),
      .out_valid (cs_vld),
      .out_data  (cs_tag),
      .out_cos   (cs_cos),
      .out_sin   (cs_sin)
   );

   // stage 1: scale products
   logic               s1_vld_ff;
   req_type            s1_tag_ff;
   logic signed [41:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [18:0] nsin;
   assign nsin = -(19'(cs_sin));

   // stage 2: rounded matrix entries
   logic               s2_vld_ff;
   req_type            s2_tag_ff;
   logic signed [31:0] m00_ff, m01_ff, m10_ff, m11_ff;

   // stage 3: pivot products
   logic               s3_vld_ff;
   req_type            s3_tag_ff;
   logic signed [31:0] m3_00_ff, m3_01_ff, m3_10_ff, m3_11_ff;
   logic signed [63:0] q00_ff, q01_ff, q10_ff, q11_ff;

   // stage 4: rounded sums and base
   logic               s4_vld_ff;
   logic signed [31:0] m4_00_ff, m4_01_ff, m4_10_ff, m4_11_ff;
   logic signed [65:0] ex_ff, ey_ff, bx_ff, by_ff;

   // stage 5: output register
   logic               s5_vld_ff;
   rsp_type            rsp_ff, rsp_in;

   function automatic logic signed [31:0] rnd_m(input logic signed [41:0] p);
      logic signed [42:0] r;
      r = (43'(p) + 43'sd32768) >>> 16;
      return r[31:0];
   endfunction

   always_comb begin
      rsp_in.m00      = m4_00_ff;
      rsp_in.m01      = m4_01_ff;
      rsp_in.m10      = m4_10_ff;
      rsp_in.m11      = m4_11_ff;
      rsp_in.offset_x = sat32(bx_ff - ex_ff);
      rsp_in.offset_y = sat32(by_ff - ey_ff);
   end

   always_ff @(posedge clock) begin
      p00_ff    <= cs_cos * cs_tag.stretch_x;
      p01_ff    <= nsin * cs_tag.stretch_y;
      p10_ff    <= cs_sin * cs_tag.stretch_x;
      p11_ff    <= cs_cos * cs_tag.stretch_y;
      s1_tag_ff <= cs_tag;

      m00_ff    <= rnd_m(p00_ff);
      m01_ff    <= rnd_m(p01_ff);
      m10_ff    <= rnd_m(p10_ff);
      m11_ff    <= rnd_m(p11_ff);
      s2_tag_ff <= s1_tag_ff;

      q00_ff    <= m00_ff * s2_tag_ff.pivot_x;
      q01_ff    <= m01_ff * s2_tag_ff.pivot_y;
      q10_ff    <= m10_ff * s2_tag_ff.pivot_x;
      q11_ff    <= m11_ff * s2_tag_ff.pivot_y;
      m3_00_ff  <= m00_ff;
      m3_01_ff  <= m01_ff;
      m3_10_ff  <= m10_ff;
      m3_11_ff  <= m11_ff;
      s3_tag_ff <= s2_tag_ff;

      ex_ff     <= (66'(q00_ff) + 66'(q01_ff) + 66'sd32768) >>> 16;
      ey_ff     <= (66'(q10_ff) + 66'(q11_ff) + 66'sd32768) >>> 16;
      bx_ff     <= 66'(s3_tag_ff.move_x) + 66'(s3_tag_ff.pivot_x);
      by_ff     <= 66'(s3_tag_ff.move_y) + 66'(s3_tag_ff.pivot_y);
      m4_00_ff  <= m3_00_ff;
      m4_01_ff  <= m3_01_ff;
      m4_10_ff  <= m3_10_ff;
      m4_11_ff  <= m3_11_ff;

      rsp_ff    <= rsp_in;

      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cs_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   assign busy      = 1'b0;
   assign rsp_valid = s5_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: verif/affine_2d_transform_matrix_test.sv
module affine_2d_transform_matrix_test;
   import aff2d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = STEPS + 8;
   localparam int CYCLE_LIMIT = 200000;

   // Fixed-point matrix builder: folds the angle, runs the CORDIC, forms
   // the scaled rotation and the pivot-corrected offset.
   class matrix_scoreboard;
      rsp_type pending[$];
      int      errors;

      function automatic longint clamp32(longint v);
         if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
         end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function automatic longint round16(longint p);
         return (p + 32768) >>> 16;
      endfunction

      function automatic rsp_type build(req_type r);
         longint ang_z, cx, cy, dx, dy, c, s;
         longint p00, p01, p10, p11, ox, oy;
         bit     negate;
         rsp_type m;
         ang_z = longint'(r.angle) * 16384;
         cx = Q30_INV_GAIN;
         cy = 0;
         negate = 0;
         if (ang_z > Q30_PI) begin
            ang_z -= Q30_TWO_PI;
         end else if (ang_z < -Q30_PI) begin
            ang_z += Q30_TWO_PI;
         end
         if (ang_z > Q30_HALF_PI) begin
            ang_z -= Q30_PI;
            negate = 1;
         end else if (ang_z < -Q30_HALF_PI) begin
            ang_z += Q30_PI;
            negate = 1;
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (ang_z >= 0) begin
               cx -= dx;
               cy += dy;
               ang_z -= longint'(ATAN_Q30[i]);
            end else begin
               cx += dx;
               cy -= dy;
               ang_z += longint'(ATAN_Q30[i]);
            end
         end
         c = (cx + 8192) >>> 14;
         s = (cy + 8192) >>> 14;
         if (negate) begin
            c = -c;
            s = -s;
         end
         p00 = clamp32(round16(c * longint'(r.stretch_x)));
         p01 = clamp32(round16(-s * longint'(r.stretch_y)));
         p10 = clamp32(round16(s * longint'(r.stretch_x)));
         p11 = clamp32(round16(c * longint'(r.stretch_y)));
         // the pivot products fit 64 bits: two 32x32 products summed
         ox = clamp32(longint'(r.move_x) + longint'(r.pivot_x)
                      - round16(p00 * r.pivot_x + p01 * r.pivot_y));
         oy = clamp32(longint'(r.move_y) + longint'(r.pivot_y)
                      - round16(p10 * r.pivot_x + p11 * r.pivot_y));
         m.m00 = p00[31:0];
         m.m01 = p01[31:0];
         m.m10 = p10[31:0];
         m.m11 = p11[31:0];
         m.offset_x = ox[31:0];
         m.offset_y = oy[31:0];
         return m;
      endfunction

      function void note_request(req_type r);
         pending.push_back(build(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.m00 !== want.m00)
            $display("%0t: m00 expected %h actual %h", $time, want.m00, got.m00);
         if (got.m01 !== want.m01)
            $display("%0t: m01 expected %h actual %h", $time, want.m01, got.m01);
         if (got.m10 !== want.m10)
            $display("%0t: m10 expected %h actual %h", $time, want.m10, got.m10);
         if (got.m11 !== want.m11)
            $display("%0t: m11 expected %h actual %h", $time, want.m11, got.m11);
         if (got.offset_x !== want.offset_x)
            $display("%0t: offset_x expected %h actual %h", $time,
                     want.offset_x, got.offset_x);
         if (got.offset_y !== want.offset_y)
            $display("%0t: offset_y expected %h actual %h", $time,
                     want.offset_y, got.offset_y);
         if (got !== want) errors++;
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   matrix_scoreboard board = new();
   int      idle_pct = 0;
   longint  cycles = 0;

   affine_2d_transform_matrix dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_valid) board.check_result(rsp_data);
   end

   function automatic logic [31:0] rand32();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         3, 4: return 32'($signed(16'($urandom)));
         5, 6: return 32'($signed(24'($urandom)));
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.move_x = rand32();
      r.move_y = rand32();
      r.pivot_x = rand32();
      r.pivot_y = rand32();
      // mostly within two pi, sometimes the full field
      if ($urandom_range(0, 4) == 0) r.angle = 20'($urandom);
      else r.angle = 20'($signed($urandom_range(0, 823550)) - 411775);
      r.stretch_x = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                    : 24'($signed($urandom_range(0, 262144)) - 131072);
      r.stretch_y = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                    : 24'($signed($urandom_range(0, 262144)) - 131072);
      return r;
   endfunction

   // Present one item and hold it until a transfer; start is left high afterwards.
   task automatic send_request(req_type r);
      while ($urandom_range(1, 100) <= idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.note_request(r);
   endtask

   task automatic finish_phase();
      start <= 0;
      @(posedge clock);
   endtask

   initial begin
      req_type r;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: angle folding boundaries, extremes of every field
      for (int k = 0; k < 22; k++) begin
         r = '0;
         r.stretch_x = 24'sh010000;
         r.stretch_y = 24'sh010000;
         r.pivot_x = 32'sh00010000;
         r.pivot_y = -32'sh00020000;
         case (k)
            0: r.angle = 20'sd0;
            1: r.angle = 20'sd102944;
            2: r.angle = -20'sd102944;
            3: r.angle = 20'sd205887;
            4: r.angle = -20'sd205887;
            5: r.angle = 20'sd205888;
            6: r.angle = 20'sd411775;
            7: r.angle = -20'sd411775;
            8: r.angle = 20'sh7ffff;
            9: r.angle = 20'sh80000;
            10: r.angle = 20'sd102943;
            11: r.angle = -20'sd102945;
            12: begin
               r.stretch_x = 24'h7fffff; r.stretch_y = 24'h800000;
               r.angle = 20'sd51472;
            end
            13: begin
               r.stretch_x = 24'h800000; r.stretch_y = 24'h7fffff;
               r.angle = 20'sd300000;
            end
            14: begin
               r.move_x = 32'h7fffffff; r.move_y = 32'h80000000;
               r.pivot_x = 32'h7fffffff; r.pivot_y = 32'h80000000;
            end
            15: begin
               r.move_x = 32'h80000000; r.move_y = 32'h7fffffff;
               r.pivot_x = 32'h80000000; r.pivot_y = 32'h7fffffff;
               r.stretch_x = 24'h7fffff; r.stretch_y = 24'h7fffff;
            end
            16: begin
               r.move_x = '1; r.move_y = '1; r.pivot_x = '1; r.pivot_y = '1;
               r.stretch_x = '1; r.stretch_y = '1; r.angle = '1;
            end
            17: begin
               r.stretch_x = '0; r.stretch_y = '0;
               r.pivot_x = 32'h7fffffff; r.pivot_y = 32'h7fffffff;
            end
            18: r.angle = 20'sd205887 + 20'sd102944;
            19: r.angle = -20'sd300000;
            20: begin
               r.stretch_x = 24'h800000; r.stretch_y = 24'h800000;
               r.angle = 20'sd205887;
               r.pivot_x = 32'h80000000; r.pivot_y = 32'h80000000;
            end
            default: r = random_request();
         endcase
         send_request(r);
      end
      finish_phase();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: idle_pct = 0;
            1: idle_pct = 47;
            2: idle_pct = 0;
            default: idle_pct = 30;
         endcase
         for (int k = 0; k < 460; k++) send_request(random_request());
         // drop start between phases
         finish_phase();
      end

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (board.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// File: files.f
src/aff2d_pkg.sv
src/aff2d_cordic.sv
src/affine_2d_transform_matrix.sv
verif/affine_2d_transform_matrix_test.sv
